### src/ffra_pkg.sv
// Shared types and constants of the first-fit range allocator.
// Depends on nothing; every other file of the block imports it.
package ffra_pkg;

	localparam int MAX_RANGES_DEF = 32;
	localparam logic [16:0] MIN_GROWTH_RST = 17'd4096;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EXHAUST = 2'd2;

	localparam logic REG_MIN_GROWTH = 1'b0;

	// One free range: first element and number of elements.
	typedef struct packed {
		logic [31:0] base;
		logic [31:0] len;
	} range_t;

	// The three cells nearest the head of the chain.
	typedef struct packed {
		range_t c0;
		range_t c1;
		range_t c2;
	} chain_view_t;

	// Shift command and the entry that enters at the tail.
	typedef struct packed {
		logic   shift;
		range_t tail;
	} chain_ctl_t;

endpackage

### src/ffra_cell.sv
// One cell of the free range chain: holds a single range entry.
// Depends on ffra_pkg for the entry type.
module ffra_cell (
	input  logic             clk,
	input  logic             shift,
	input  ffra_pkg::range_t d,
	output ffra_pkg::range_t q
);
	import ffra_pkg::*;

	range_t entry_q;

	// On a shift the cell takes its input d: its right neighbor, or the tail entry for the last cell.
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

### src/ffra_ctrl.sv
// Sequencer of the range allocator: scan pass, decision steps, rewrite pass.
// Depends on ffra_pkg; drives the cell chain through a chain_ctl_t.
module ffra_ctrl #(
	parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [31:0]           req_size,
	input  logic [31:0]           free_pos,
	input  logic [16:0]           min_growth,
	input  ffra_pkg::chain_view_t view,
	output ffra_pkg::chain_ctl_t  ctl,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           offset,
	output logic [1:0]            status,
	output logic                  grew,
	output logic [31:0]           buffer_size
);
	import ffra_pkg::*;

	localparam int IW = (MAX_RANGES > 2) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);

	localparam logic [1:0] SEL_HOLD = 2'd0;
	localparam logic [1:0] SEL_C0   = 2'd1;
	localparam logic [1:0] SEL_C1   = 2'd2;
	localparam logic [1:0] SEL_C2   = 2'd3;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_SCAN  = 12'b000000000010,
		S_DEC   = 12'b000000000100,
		S_GR1   = 12'b000000001000,
		S_GR2   = 12'b000000010000,
		S_GR3   = 12'b000000100000,
		S_INS1  = 12'b000001000000,
		S_INS2  = 12'b000010000000,
		S_INS3  = 12'b000100000000,
		S_TAKE  = 12'b001000000000,
		S_WRITE = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   t_q;
	logic [CW-1:0]   count_q;
	logic [31:0]     total_q;
	logic            out_valid_q;

	logic            cmd_q;
	logic [31:0]     size_q, scan_pos_q, ins_pos_q, ins_len_q;
	logic            fit_found_q, ins_found_q;
	logic [CW-1:0]   fit_idx_q, idx_q, e_q;
	range_t          fit_q, p1_q, p2_q, n0_q, n1_q, w_q, h_q;
	logic            p1v_q, p2v_q, n0v_q, n1v_q, wv_q;
	logic [1:0]      c_q;
	logic            lge_q;
	logic [31:0]     d_q, grow_q;
	logic            a_q, pe_q, ppe_q, cn_q, aj_q, bj_q, cj_q;
	logic [31:0]     la_q, lb_q, lc_q, lbj_q, lcj_q;
	logic [31:0]     res_offset_q;
	logic [1:0]      res_status_q;
	logic            res_grew_q;
	logic [31:0]     offset_q, buffer_size_q;
	logic [1:0]      status_q;
	logic            grew_q;

	logic            accept, out_load, last_t, vld, n1ok, free_bad, full, can;
	logic            case_a, case_b, case_c, jp;
	logic [CW-1:0]   t_ext, e_n;
	logic [1:0]      sel, c_n;
	logic [2:0]      sel_w;
	logic [32:0]     fsum, gsum;
	logic [31:0]     ga, gb, gm, minv, grow_n, l_n, add_n, base_n;
	range_t          y;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign t_ext    = CW'(t_q);
	assign last_t   = (t_q == IW'(MAX_RANGES - 1));
	assign vld      = t_ext < count_q;
	assign n1ok     = (t_ext + CW'(1)) < count_q;
	assign fsum     = {1'b0, free_pos} + {1'b0, req_size};
	assign free_bad = fsum > {1'b0, total_q};
	assign minv     = (min_growth == '0) ? 32'd1 : {15'd0, min_growth};
	assign gsum     = {1'b0, total_q} + {1'b0, grow_q};
	assign full     = (count_q == CW'(MAX_RANGES));

	// Growth amount: the larger of two candidates, then at least the minimum.
	always_comb begin
		ga     = lge_q ? d_q : size_q;
		gb     = lge_q ? total_q : {1'b0, total_q[31:1]};
		gm     = (ga > gb) ? ga : gb;
		grow_n = (gm > minv) ? gm : minv;
	end

	// Insert decision: which old entries fold into one new entry.
	always_comb begin
		case_a = a_q;
		case_b = !a_q && pe_q;
		case_c = !a_q && !pe_q && cn_q;
		can    = !full || case_a || case_b || case_c;
		jp     = 1'b0;
		l_n    = ins_len_q;
		base_n = ins_pos_q;
		add_n  = '0;
		e_n    = idx_q;
		c_n    = 2'd0;
		if (case_a) begin
			jp     = pe_q;
			l_n    = aj_q ? la_q : ins_len_q;
			base_n = jp ? p1_q.base : ins_pos_q;
			add_n  = jp ? p1_q.len : 32'd0;
			e_n    = jp ? (idx_q - CW'(1)) : idx_q;
			c_n    = 2'd1 + {1'b0, aj_q} + {1'b0, jp};
		end else if (case_b) begin
			jp     = ppe_q;
			l_n    = bj_q ? lbj_q : lb_q;
			base_n = jp ? p2_q.base : p1_q.base;
			add_n  = jp ? p2_q.len : 32'd0;
			e_n    = jp ? (idx_q - CW'(2)) : (idx_q - CW'(1));
			c_n    = 2'd1 + {1'b0, bj_q} + {1'b0, jp};
		end else if (case_c) begin
			l_n    = cj_q ? lcj_q : lc_q;
			c_n    = 2'd1 + {1'b0, cj_q};
		end
	end

	// Rewrite pass: output slot t takes an old slot shifted by consumed minus written.
	assign sel_w = {1'b0, c_q} + 3'd1 - {2'd0, wv_q};
	assign sel   = sel_w[1:0];

	always_comb begin
		if (t_ext < e_q) begin
			y = view.c0;
		end else if ((t_ext == e_q) && wv_q) begin
			y = w_q;
		end else begin
			case (sel)
				SEL_HOLD: y = h_q;
				SEL_C0:   y = view.c0;
				SEL_C1:   y = view.c1;
				SEL_C2:   y = view.c2;
				default:  y = view.c0;
			endcase
		end
	end

	assign ctl.shift = (state_q == S_SCAN) || (state_q == S_WRITE);
	assign ctl.tail  = (state_q == S_WRITE) ? y : view.c0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			t_q         <= '0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						t_q <= '0;
						if (cmd == CMD_FREE && (req_size == '0 || free_bad)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					t_q <= t_q + IW'(1);
					if (last_t) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					t_q <= '0;
					if (cmd_q == CMD_FREE) begin
						state_q <= S_INS1;
					end else if (fit_found_q) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_GR1;
					end
				end
				S_GR1: state_q <= S_GR2;
				S_GR2: state_q <= S_GR3;
				S_GR3: state_q <= gsum[32] ? S_DONE : S_INS1;
				S_INS1: state_q <= S_INS2;
				S_INS2: state_q <= S_INS3;
				S_INS3: begin
					if (!can) begin
						state_q <= S_DONE;
					end else if (cmd_q == CMD_ALLOC) begin
						state_q <= S_TAKE;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_TAKE: begin
					total_q <= gsum[31:0];
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					t_q <= t_q + IW'(1);
					if (last_t) begin
						count_q <= count_q - CW'(c_q) + CW'(wv_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q        <= cmd;
					size_q       <= req_size;
					scan_pos_q   <= (cmd == CMD_FREE) ? free_pos : total_q;
					ins_pos_q    <= free_pos;
					ins_len_q    <= req_size;
					fit_found_q  <= 1'b0;
					ins_found_q  <= 1'b0;
					p1v_q        <= 1'b0;
					p2v_q        <= 1'b0;
					n0v_q        <= 1'b0;
					n1v_q        <= 1'b0;
					idx_q        <= count_q;
					res_offset_q <= '0;
					res_grew_q   <= 1'b0;
					res_status_q <= (cmd == CMD_FREE && req_size != '0 && free_bad)
						? ST_EXHAUST : ST_OK;
				end
			end
			S_SCAN: begin
				if (vld) begin
					if (!fit_found_q && view.c0.len >= size_q) begin
						fit_found_q <= 1'b1;
						fit_idx_q   <= t_ext;
						fit_q       <= view.c0;
					end
					if (!ins_found_q) begin
						if (view.c0.base >= scan_pos_q) begin
							ins_found_q <= 1'b1;
							idx_q       <= t_ext;
							n0_q        <= view.c0;
							n0v_q       <= 1'b1;
							n1_q        <= view.c1;
							n1v_q       <= n1ok;
						end else begin
							p2_q  <= p1_q;
							p2v_q <= p1v_q;
							p1_q  <= view.c0;
							p1v_q <= 1'b1;
						end
					end
				end
			end
			S_DEC: begin
				if (cmd_q == CMD_ALLOC && fit_found_q) begin
					res_offset_q <= fit_q.base;
					w_q.base     <= fit_q.base + size_q;
					w_q.len      <= fit_q.len - size_q;
					wv_q         <= (fit_q.len != size_q);
					e_q          <= fit_idx_q;
					c_q          <= 2'd1;
				end
			end
			S_GR1: begin
				// The last range only exists when the table is not empty.
				lge_q <= p1v_q && (({1'b0, p1_q.base} + {1'b0, p1_q.len}) >= {1'b0, total_q});
				d_q   <= size_q - p1_q.len;
			end
			S_GR2: grow_q <= grow_n;
			S_GR3: begin
				if (gsum[32]) begin
					res_status_q <= ST_EXHAUST;
				end else begin
					ins_pos_q <= total_q;
					ins_len_q <= grow_q;
				end
			end
			S_INS1: begin
				a_q   <= n0v_q && (n0_q.base == ins_pos_q);
				pe_q  <= p1v_q && (({1'b0, p1_q.base} + {1'b0, p1_q.len}) == {1'b0, ins_pos_q});
				ppe_q <= p2v_q && (({1'b0, p2_q.base} + {1'b0, p2_q.len}) == {1'b0, p1_q.base});
				cn_q  <= n0v_q && (({1'b0, ins_pos_q} + {1'b0, ins_len_q}) == {1'b0, n0_q.base});
				aj_q  <= n1v_q && (({1'b0, ins_pos_q} + {1'b0, ins_len_q}) == {1'b0, n1_q.base});
				la_q  <= ins_len_q + n1_q.len;
				lb_q  <= p1_q.len + ins_len_q;
				lc_q  <= n0_q.len + ins_len_q;
			end
			S_INS2: begin
				bj_q  <= n0v_q && (({1'b0, p1_q.base} + {1'b0, lb_q}) == {1'b0, n0_q.base});
				cj_q  <= n1v_q && (({1'b0, ins_pos_q} + {1'b0, lc_q}) == {1'b0, n1_q.base});
				lbj_q <= lb_q + n0_q.len;
				lcj_q <= lc_q + n1_q.len;
			end
			S_INS3: begin
				if (!can) begin
					res_status_q <= ST_FULL;
				end else begin
					w_q.base <= base_n;
					w_q.len  <= add_n + l_n;
					wv_q     <= 1'b1;
					e_q      <= e_n;
					c_q      <= c_n;
				end
			end
			S_TAKE: begin
				res_offset_q <= w_q.base;
				res_grew_q   <= 1'b1;
				w_q.base     <= w_q.base + size_q;
				w_q.len      <= w_q.len - size_q;
				wv_q         <= (w_q.len != size_q);
			end
			S_WRITE: h_q <= view.c0;
			S_DONE: begin
				if (out_load) begin
					offset_q      <= res_offset_q;
					status_q      <= res_status_q;
					grew_q        <= res_grew_q;
					buffer_size_q <= total_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign offset      = offset_q;
	assign status      = status_q;
	assign grew        = grew_q;
	assign buffer_size = buffer_size_q;

endmodule

### src/first_fit_range_allocator.sv
// Every allocate and every valid free scans the table; a free of zero length or past the
// end skips the scan. One command at a time: the chain is rotated fully to scan it, and
// again to rewrite it when the table changes. The result sits in an output register, so
// the next beat is taken meanwhile.
// Reset: asynchronous, active low; empties the table, zeroes the buffer size, sets min_growth
// to 4096. The range entries themselves are not cleared; the fill count masks them.
module first_fit_range_allocator #(
	parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Command channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] req_size,
	input  logic [31:0] free_pos,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] offset,
	output logic [1:0]  status,
	output logic        grew,
	output logic [31:0] buffer_size,
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ffra_pkg::*;

	// For a two-entry table the third view tap is never used; it aliases the last cell.
	localparam int I2 = (MAX_RANGES > 2) ? 2 : MAX_RANGES - 1;

	logic [16:0] min_growth_q;
	chain_view_t view;
	chain_ctl_t  ctl;
	range_t      cell_q [MAX_RANGES];

	// The register port has one register; the upper word address is ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_GROWTH) ? {15'd0, min_growth_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_growth_q <= MIN_GROWTH_RST;
		end else if (psel && penable && pwrite && paddr[2] == REG_MIN_GROWTH) begin
			min_growth_q <= pwdata[16:0];
		end
	end

	// The free ranges live in a row of cells kept sorted by start offset. Every command but a
	// rejected free rotates the row once to see all entries in order through the head cell, and, when
	// the table changes, once more while the sequencer feeds the edited sequence into the tail.
	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		range_t d;
		if (i == MAX_RANGES - 1) begin : g_tail
			assign d = ctl.tail;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		ffra_cell u_cell (
			.clk   (clk),
			.shift (ctl.shift),
			.d     (d),
			.q     (cell_q[i])
		);
	end

	assign view.c0 = cell_q[0];
	assign view.c1 = cell_q[1];
	assign view.c2 = cell_q[I2];

	ffra_ctrl #(
		.MAX_RANGES (MAX_RANGES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.req_size    (req_size),
		.free_pos    (free_pos),
		.min_growth  (min_growth_q),
		.view        (view),
		.ctl         (ctl),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.offset      (offset),
		.status      (status),
		.grew        (grew),
		.buffer_size (buffer_size)
	);

endmodule
